@@ rtl/palette_store_nearest_color_assert.svh @@
// Assertion macros shared by the palette store. Each macro expects clk and
// rst_n in scope and expands to one labeled concurrent assertion.
`ifndef PALETTE_STORE_NEAREST_COLOR_ASSERT_SVH
`define PALETTE_STORE_NEAREST_COLOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSNC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSNC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/psnc_pkg.sv @@
// ----------------------------------------------------------------------------
// psnc_pkg
// Types and constants shared by the palette store with nearest-color search.
// ----------------------------------------------------------------------------
package psnc_pkg;

  localparam int IDX_W   = 8;
  localparam int CHAN_W  = 8;
  localparam int NUM_W   = 9;
  localparam int DIST_W  = 18;
  localparam int WORD_W  = 32;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int MAX_ENTRIES = 256;

  localparam logic [NUM_W-1:0]  NUM_ENTRIES_RESET = 9'd256;
  localparam logic [DIST_W-1:0] DIST_INIT         = '1;
  localparam logic [DIST_W-1:0] DIST_MAX          = 18'd195075;
  localparam logic [1:0]        Q_DEPTH           = 2'd2;

  // Word index of the configuration registers.
  localparam logic REG_NUM_ENTRIES = 1'b0;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    func_t             op;
    logic              oor;
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] flags;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic [IDX_W-1:0]  result_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] flags;
    logic [DIST_W-1:0] distance;
  } res_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_RESP
  } back_state_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ rtl/psnc_ram.sv @@
// ----------------------------------------------------------------------------
// psnc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module psnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/psnc_front.sv @@
// ----------------------------------------------------------------------------
// psnc_front
// Accepts input items, decodes the operation and range-checks the index.
// ----------------------------------------------------------------------------
module psnc_front import psnc_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [CHAN_W-1:0]  in_red,
  input  logic [CHAN_W-1:0]  in_green,
  input  logic [CHAN_W-1:0]  in_blue,
  input  logic [CHAN_W-1:0]  in_entry_flags,
  input  logic [NUM_W-1:0]   num_used,
  input  q_stat_t            q_stat,
  output logic               push,
  output cmd_t               cmd
);

  func_t op;
  logic  addressed;

  assign op        = func_t'(in_func);
  assign addressed = (op == FUNC_WRITE) || (op == FUNC_READ);

  always_comb begin
    cmd.op    = op;
    // Only writes and reads carry an index that must lie within the palette.
    cmd.oor   = addressed && ({1'b0, in_entry_index} >= num_used);
    cmd.idx   = in_entry_index;
    cmd.red   = in_red;
    cmd.green = in_green;
    cmd.blue  = in_blue;
    cmd.flags = in_entry_flags;
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

endmodule

@@ rtl/psnc_queue.sv @@
// ----------------------------------------------------------------------------
// psnc_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module psnc_queue import psnc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == Q_DEPTH);
  assign q_stat.empty = (count_r == 2'd0);
  assign q_stat.count = count_r;

endmodule

@@ rtl/psnc_back.sv @@
// ----------------------------------------------------------------------------
// psnc_back
// Executes queued commands against the palette RAM: writes, reads and the
// nearest-color scan, and holds the result in the output register.
// ----------------------------------------------------------------------------
module psnc_back import psnc_pkg::*; #(
  parameter int MEM_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  input  logic [NUM_W-1:0] num_used,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             res
);

  localparam int AW = $clog2(MEM_DEPTH);

  back_state_t state_r, state_nxt;
  cmd_t        cur_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [NUM_W-1:0]  scan_ptr_r;
  logic              v1_r, v2_r;
  logic [AW-1:0]     idx1_r, idx2_r;
  logic [15:0]       sq_red_r, sq_green_r, sq_blue_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [DIST_W-1:0] dist_sum;

  logic [CHAN_W-1:0] d_red, d_green, d_blue;
  logic              issue, scan_done, out_free, load_out, show_word, is_query;
  logic              out_valid_r;
  res_t              res_r;

  psnc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign issue     = (state_r == BK_SCAN) && (scan_ptr_r != num_used);
  assign scan_done = (state_r == BK_SCAN) && (scan_ptr_r == num_used) && !v1_r && !v2_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.op == FUNC_QUERY) ? BK_SCAN : BK_RESP;
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          state_nxt = BK_RESP;
        end
      end
      BK_RESP: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop and RAM port controls.
  always_comb begin
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = cmd.idx[AW-1:0];
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        cmd_pop = cmd_valid;
        ram_we  = cmd_valid && (cmd.op == FUNC_WRITE) && !cmd.oor;
        ram_re  = cmd_valid && (cmd.op == FUNC_READ) && !cmd.oor;
      end
      BK_SCAN: begin
        // After the last compare, the winning entry is fetched once more.
        ram_re    = issue || scan_done;
        ram_raddr = issue ? scan_ptr_r[AW-1:0] : best_idx_r[AW-1:0];
      end
      BK_RESP: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  assign ram_waddr = cmd.idx[AW-1:0];
  assign ram_wdata = {cmd.flags, cmd.blue, cmd.green, cmd.red};

  assign d_red    = abs_diff(cur_r.red,   ram_rdata[7:0]);
  assign d_green  = abs_diff(cur_r.green, ram_rdata[15:8]);
  assign d_blue   = abs_diff(cur_r.blue,  ram_rdata[23:16]);
  assign dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd;
    end
    idx1_r     <= scan_ptr_r[AW-1:0];
    idx2_r     <= idx1_r;
    sq_red_r   <= 16'(d_red)   * 16'(d_red);
    sq_green_r <= 16'(d_green) * 16'(d_green);
    sq_blue_r  <= 16'(d_blue)  * 16'(d_blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      scan_ptr_r  <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      best_idx_r  <= '0;
      best_dist_r <= DIST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      if (cmd_pop && (cmd.op == FUNC_QUERY)) begin
        scan_ptr_r  <= '0;
        best_idx_r  <= '0;
        best_dist_r <= DIST_INIT;
      end else begin
        if (issue) begin
          scan_ptr_r <= scan_ptr_r + 1'b1;
        end
        // Strict less-than keeps the lowest index on a tie.
        if (v2_r && (dist_sum < best_dist_r)) begin
          best_dist_r <= dist_sum;
          best_idx_r  <= IDX_W'(idx2_r);
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign is_query  = (cur_r.op == FUNC_QUERY);
  assign show_word = ((cur_r.op == FUNC_READ) && !cur_r.oor) ||
                     (is_query && (num_used != '0));

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_r.status       <= cur_r.oor;
      res_r.result_index <= is_query ? best_idx_r : cur_r.idx;
      res_r.red          <= show_word ? ram_rdata[7:0]   : '0;
      res_r.green        <= show_word ? ram_rdata[15:8]  : '0;
      res_r.blue         <= show_word ? ram_rdata[23:16] : '0;
      res_r.flags        <= show_word ? ram_rdata[31:24] : '0;
      res_r.distance     <= (is_query && (num_used != '0)) ? best_dist_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

@@ rtl/palette_store_nearest_color.sv @@
// ----------------------------------------------------------------------------
// palette_store_nearest_color
// Palette store with write, read and nearest-color (squared RGB) search.
//
//   channel  handshake          contents
//   in_      in_valid/in_ready  func, entry_index, red, green, blue, flags
//   out_     out_valid/out_ready status, index, color, flags, distance
//   config   APB psel/penable   num_entries at byte address 0
//
// A write or read is popped from the queue in BK_IDLE and loaded into
// the output register from BK_RESP, which raises out_valid. A nearest
// query also passes through BK_SCAN, which reads one palette entry per
// cycle through the single RAM read port.
// Reset is synchronous; the palette RAM is not cleared and needs no sweep.
// Up to two items wait in the queue while the back end works or its output
// register is stalled.
// ----------------------------------------------------------------------------
module palette_store_nearest_color import psnc_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic [CHAN_W-1:0]   in_red,
  input  logic [CHAN_W-1:0]   in_green,
  input  logic [CHAN_W-1:0]   in_blue,
  input  logic [CHAN_W-1:0]   in_entry_flags,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_status,
  output logic [IDX_W-1:0]    out_result_index,
  output logic [CHAN_W-1:0]   out_red,
  output logic [CHAN_W-1:0]   out_green,
  output logic [CHAN_W-1:0]   out_blue,
  output logic [CHAN_W-1:0]   out_flags,
  output logic [DIST_W-1:0]   out_best_distance,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

`include "palette_store_nearest_color_assert.svh"

  // Entries beyond the 8-bit index space can never be addressed.
  localparam int MemDepth = (PALETTE_DEPTH < MAX_ENTRIES) ? PALETTE_DEPTH : MAX_ENTRIES;
  localparam logic [NUM_W-1:0] MaxCount = NUM_W'(MemDepth);

  logic [NUM_W-1:0] num_entries_r;
  logic [NUM_W-1:0] num_used;
  logic             cfg_wr;
  logic             push, pop;
  cmd_t             push_cmd, head;
  q_stat_t          q_stat;
  res_t             res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_NUM_ENTRIES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_entries_r <= NUM_ENTRIES_RESET;
    end else if (cfg_wr) begin
      num_entries_r <= pwdata[NUM_W-1:0];
    end
  end

  assign prdata   = (paddr[CFG_AW-1] == REG_NUM_ENTRIES) ? CFG_DW'(num_entries_r) : '0;
  assign num_used = (num_entries_r > MaxCount) ? MaxCount : num_entries_r;

  psnc_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_entry_index(in_entry_index),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_entry_flags(in_entry_flags),
    .num_used      (num_used),
    .q_stat        (q_stat),
    .push          (push),
    .cmd           (push_cmd)
  );

  psnc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  psnc_back #(
    .MEM_DEPTH(MemDepth)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(!q_stat.empty),
    .cmd      (head),
    .cmd_pop  (pop),
    .num_used (num_used),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res)
  );

  assign out_status        = res.status;
  assign out_result_index  = res.result_index;
  assign out_red           = res.red;
  assign out_green         = res.green;
  assign out_blue          = res.blue;
  assign out_flags         = res.flags;
  assign out_best_distance = res.distance;

  `PSNC_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= Q_DEPTH, "queue count exceeds depth")
  `PSNC_ASSERT_NOW(a_oor_no_dist, out_valid && out_status, out_best_distance == '0,
                   "out-of-range result carries a distance")
  `PSNC_ASSERT_NOW(a_dist_bound, out_valid, out_best_distance <= DIST_MAX,
                   "distance above the largest squared RGB distance")
  `PSNC_ASSERT_NEXT(a_push_counts, push && !pop, q_stat.count == $past(q_stat.count) + 2'd1,
                    "queue count did not advance on push")

endmodule

@@ tb/palette_store_nearest_color_test.sv @@
// ----------------------------------------------------------------------------
// palette_store_nearest_color_test
// Self-checking bench for the palette store. A directed table covers the
// range checks, the empty palette, ties, exact hits and the largest distance.
// Random phases then run writes, reads and nearest queries at several entry
// counts, with bursty input and a stalling receiver. Every result item is
// checked against its table row or a shadow palette kept in the bench.
// ----------------------------------------------------------------------------
module palette_store_nearest_color_test;
  import psnc_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int LIMIT_CYCLES  = 3000000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [CFG_AW-1:0] ENTRY_COUNT_ADDR = CFG_AW'(4 * REG_NUM_ENTRIES);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] flags;
  } pal_entry_t;

  typedef struct {
    int                set_count;  // entry count written first, -1 for none
    logic [1:0]        op;
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] flags;
    bit                known;
    res_t              want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_func = FUNC_NONE;
  logic [IDX_W-1:0]    in_entry_index = '0;
  logic [CHAN_W-1:0]   in_red = '0;
  logic [CHAN_W-1:0]   in_green = '0;
  logic [CHAN_W-1:0]   in_blue = '0;
  logic [CHAN_W-1:0]   in_entry_flags = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_status;
  logic [IDX_W-1:0]    out_result_index;
  logic [CHAN_W-1:0]   out_red;
  logic [CHAN_W-1:0]   out_green;
  logic [CHAN_W-1:0]   out_blue;
  logic [CHAN_W-1:0]   out_flags;
  logic [DIST_W-1:0]   out_best_distance;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // Shadow copy of the block's state.
  pal_entry_t        shadow_palette [MAX_ENTRIES];
  bit                entry_loaded [MAX_ENTRIES];
  logic [NUM_W-1:0]  entry_count_reg = NUM_ENTRIES_RESET;

  res_t awaited_results [$];
  res_t arrived;
  int   fail_count = 0;
  int   burst_left = 0;
  int   ready_left = 0;
  int   ready_mode = 0;
  int   ready_tick = 0;

  palette_store_nearest_color dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_entry_flags    (in_entry_flags),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_result_index  (out_result_index),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_flags         (out_flags),
    .out_best_distance (out_best_distance),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

  // Entries in use: the register value clamped to the palette size.
  function automatic int entries_in_use();
    return (int'(entry_count_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count_reg);
  endfunction

  function automatic int color_distance(input pal_entry_t e, input logic [CHAN_W-1:0] r,
                                        input logic [CHAN_W-1:0] g,
                                        input logic [CHAN_W-1:0] b);
    int dr, dg, db;
    dr = int'(r) - int'(e.red);
    dg = int'(g) - int'(e.green);
    db = int'(b) - int'(e.blue);
    return dr * dr + dg * dg + db * db;
  endfunction

  // Applies one item to the shadow palette and returns the result it gives.
  function automatic res_t apply_palette_op(input logic [1:0] op,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [CHAN_W-1:0] r,
                                            input logic [CHAN_W-1:0] g,
                                            input logic [CHAN_W-1:0] b,
                                            input logic [CHAN_W-1:0] f);
    res_t res;
    int   n;
    int   best_d;
    int   best_i;
    int   d;
    res = '0;
    res.result_index = idx;
    n = entries_in_use();
    case (op)
      FUNC_WRITE, FUNC_READ: begin
        if (int'(idx) >= n) begin
          res.status = 1'b1;
        end else if (op == FUNC_WRITE) begin
          shadow_palette[idx] = '{r, g, b, f};
          entry_loaded[idx] = 1'b1;
        end else begin
          {res.red, res.green, res.blue, res.flags} = shadow_palette[idx];
        end
      end
      FUNC_QUERY: begin
        best_d = int'(DIST_INIT);
        best_i = 0;
        for (int i = 0; i < n; i++) begin
          d = color_distance(shadow_palette[i], r, g, b);
          if (d < best_d) begin
            best_d = d;
            best_i = i;
          end
        end
        res.result_index = IDX_W'(best_i);
        if (n > 0) begin
          {res.red, res.green, res.blue, res.flags} = shadow_palette[best_i];
          res.distance = DIST_W'(best_d);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offers one item, waits for its acceptance and then paces the next one.
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                           input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] f,
                           input bit known, input res_t want);
    res_t predicted;
    int   gap;
    in_valid       <= 1'b1;
    in_func        <= op;
    in_entry_index <= idx;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_entry_flags <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_palette_op(op, idx, r, g, b, f);
    awaited_results.push_back(known ? want : predicted);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stops offering items and waits until every awaited result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Writes the entry count register and reads it back.
  task automatic set_entry_count(input logic [NUM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENTRY_COUNT_ADDR;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    entry_count_reg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DW'(value)) begin
      $error("prdata expected %0d got %0d", value, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Color bytes lean toward the corners so that ties and exact hits are common.
  function automatic logic [CHAN_W-1:0] color_byte();
    logic [CHAN_W-1:0] corners [4];
    corners = '{8'h00, 8'h01, 8'h80, 8'hFF};
    return ($urandom_range(0, 1) == 0) ? CHAN_W'($urandom_range(0, 255))
                                       : corners[$urandom_range(0, 3)];
  endfunction

  // Mostly in range if n > 0; past the end where the palette allows it.
  function automatic logic [IDX_W-1:0] pick_index(input int n);
    if (n == 0) return IDX_W'($urandom_range(0, 255));
    if (n < MAX_ENTRIES && $urandom_range(0, 6) == 0)
      return IDX_W'($urandom_range(n, 255));
    return IDX_W'($urandom_range(0, n - 1));
  endfunction

  task automatic run_random_phase(input logic [NUM_W-1:0] setting, input int item_count);
    int                n;
    int                roll;
    int                pick;
    logic [CHAN_W-1:0] r, g, b;
    drain_results();
    set_entry_count(setting);
    n = entries_in_use();
    // Every entry in use gets written before any query may scan it.
    for (int i = 0; i < n; i++) begin
      if (!entry_loaded[i])
        send_item(FUNC_WRITE, IDX_W'(i), color_byte(), color_byte(), color_byte(),
                  CHAN_W'($urandom_range(0, 255)), 1'b0, '0);
    end
    for (int k = 0; k < item_count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        send_item(FUNC_WRITE, pick_index(n), color_byte(), color_byte(), color_byte(),
                  CHAN_W'($urandom_range(0, 255)), 1'b0, '0);
      end else if (roll < 55) begin
        send_item(FUNC_READ, pick_index(n), CHAN_W'($urandom()), CHAN_W'($urandom()),
                  CHAN_W'($urandom()), CHAN_W'($urandom()), 1'b0, '0);
      end else if (roll < 92) begin
        if (n > 0 && $urandom_range(0, 2) == 0) begin
          pick = $urandom_range(0, n - 1);
          r = shadow_palette[pick].red ^ CHAN_W'($urandom_range(0, 1));
          g = shadow_palette[pick].green;
          b = shadow_palette[pick].blue;
        end else begin
          r = color_byte();
          g = color_byte();
          b = color_byte();
        end
        send_item(FUNC_QUERY, IDX_W'($urandom()), r, g, b, CHAN_W'($urandom()),
                  1'b0, '0);
      end else begin
        send_item(FUNC_NONE, IDX_W'($urandom()), CHAN_W'($urandom()), CHAN_W'($urandom()),
                  CHAN_W'($urandom()), CHAN_W'($urandom()), 1'b0, '0);
      end
      if (k % 97 == 96) drain_results();
    end
  endtask

  // The receiver switches among steady, light, heavy and periodic stalling.
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(16, 400);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (ready_tick % 8 < 5);
    endcase
  end

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s expected %0d got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result item arrived with nothing awaited");
        fail_count++;
      end else begin
        arrived = awaited_results.pop_front();
        check_field("out_status", arrived.status, out_status);
        check_field("out_result_index", arrived.result_index, out_result_index);
        check_field("out_red", arrived.red, out_red);
        check_field("out_green", arrived.green, out_green);
        check_field("out_blue", arrived.blue, out_blue);
        check_field("out_flags", arrived.flags, out_flags);
        check_field("out_best_distance", arrived.distance, out_best_distance);
      end
    end
  end

  dir_row_t dir_rows [] = '{
    // Empty palette, out-of-range write and read, unused operation code.
    '{0,  FUNC_QUERY, 8'h3C, 8'd10, 8'd20, 8'd30, 8'h11, 1, '{0, 8'h00, 0, 0, 0, 0, 0}},
    '{-1, FUNC_WRITE, 8'h00, 8'd1,  8'd2,  8'd3,  8'd4,  1, '{1, 8'h00, 0, 0, 0, 0, 0}},
    '{-1, FUNC_READ,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1, '{1, 8'hFF, 0, 0, 0, 0, 0}},
    '{-1, FUNC_NONE,  8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, '{0, 8'hA5, 0, 0, 0, 0, 0}},
    // Four entries, two of them equal to force a tie.
    '{4,  FUNC_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, '{0, 8'h00, 0, 0, 0, 0, 0}},
    '{-1, FUNC_WRITE, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, '{0, 8'h01, 0, 0, 0, 0, 0}},
    '{-1, FUNC_WRITE, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h5A, 1, '{0, 8'h02, 0, 0, 0, 0, 0}},
    '{-1, FUNC_WRITE, 8'h03, 8'h0C, 8'h22, 8'h38, 8'hC3, 1, '{0, 8'h03, 0, 0, 0, 0, 0}},
    '{-1, FUNC_WRITE, 8'h04, 8'h55, 8'h66, 8'h77, 8'h88, 1, '{1, 8'h04, 0, 0, 0, 0, 0}},
    '{-1, FUNC_READ,  8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 1, '{1, 8'h04, 0, 0, 0, 0, 0}},
    '{-1, FUNC_READ,  8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1,
      '{0, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0}},
    '{-1, FUNC_READ,  8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 1,
      '{0, 8'h03, 8'h0C, 8'h22, 8'h38, 8'hC3, 0}},
    '{-1, FUNC_QUERY, 8'h07, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1,
      '{0, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0}},
    '{-1, FUNC_QUERY, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 1, '{0, 8'h00, 0, 0, 0, 0, 0}},
    '{-1, FUNC_QUERY, 8'hF0, 8'h0C, 8'h22, 8'h38, 8'h00, 1,
      '{0, 8'h03, 8'h0C, 8'h22, 8'h38, 8'hC3, 0}},
    '{-1, FUNC_QUERY, 8'h00, 8'h80, 8'h80, 8'h80, 8'h00, 0, '0},
    '{-1, FUNC_WRITE, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h81, 1, '{0, 8'h00, 0, 0, 0, 0, 0}},
    // One entry at the opposite corner gives the largest possible distance.
    '{1,  FUNC_QUERY, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 1,
      '{0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h81, 18'd195075}},
    '{-1, FUNC_WRITE, 8'h01, 8'h12, 8'h34, 8'h56, 8'h78, 1, '{1, 8'h01, 0, 0, 0, 0, 0}},
    // An oversized count is clamped, so the last entry is in range.
    '{511, FUNC_WRITE, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 1, '{0, 8'hFF, 0, 0, 0, 0, 0}},
    '{-1, FUNC_READ,  8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1,
      '{0, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 0}},
    '{2,  FUNC_QUERY, 8'h5A, 8'h40, 8'h40, 8'h40, 8'hA5, 0, '0},
    '{-1, FUNC_QUERY, 8'hC3, 8'hFF, 8'h80, 8'hFF, 8'h3C, 0, '0}
  };

  int phase_setting [12] = '{256, 3, 1, 511, 40, 2, 0, 129, 17, 300, 255, 6};

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_count >= 0) begin
        drain_results();
        set_entry_count(NUM_W'(dir_rows[i].set_count));
      end
      send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].red, dir_rows[i].green,
                dir_rows[i].blue, dir_rows[i].flags, dir_rows[i].known, dir_rows[i].want);
    end
    foreach (phase_setting[p])
      run_random_phase(NUM_W'(phase_setting[p]), (phase_setting[p] > 64) ? 80 : 170);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/psnc_pkg.sv
rtl/psnc_ram.sv
rtl/psnc_front.sv
rtl/psnc_queue.sv
rtl/psnc_back.sv
rtl/palette_store_nearest_color.sv
tb/palette_store_nearest_color_test.sv
